// File: hdl/bcc_pkg.sv
// bcc_pkg: shared types, opcodes and commands of the byte-code cpu core
// no dependencies
package bcc_pkg;

  localparam int MEM_DEPTH   = 65536;
  localparam int STACK_DEPTH = 16;
  localparam int MEM_AW      = $clog2(MEM_DEPTH);
  localparam int SP_W        = $clog2(STACK_DEPTH);

  typedef enum logic [1:0] {
    CMD_MEM_WR = 2'd0,
    CMD_KEY    = 2'd1,
    CMD_EXEC   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  localparam logic [7:0] OP_JMP    = 8'h00;
  localparam logic [7:0] OP_JMPI   = 8'h01;
  localparam logic [7:0] OP_JMPR   = 8'h02;
  localparam logic [7:0] OP_MOV    = 8'h03;
  localparam logic [7:0] OP_LDST   = 8'h04;
  localparam logic [7:0] OP_EXT05  = 8'h05;
  localparam logic [7:0] OP_ALUI   = 8'h06;
  localparam logic [7:0] OP_ADD    = 8'h07;
  localparam logic [7:0] OP_SUB    = 8'h08;
  localparam logic [7:0] OP_RSB    = 8'h09;
  localparam logic [7:0] OP_MUL    = 8'h0a;
  localparam logic [7:0] OP_OR     = 8'h0b;
  localparam logic [7:0] OP_AND    = 8'h0c;
  localparam logic [7:0] OP_XOR    = 8'h0d;
  localparam logic [7:0] OP_SHR    = 8'h0e;
  localparam logic [7:0] OP_SHL    = 8'h0f;
  localparam logic [7:0] OP_RET    = 8'h10;
  localparam logic [7:0] OP_CALL   = 8'h11;
  localparam logic [7:0] OP_POPM   = 8'h12;
  localparam logic [7:0] OP_PUSHM  = 8'h13;
  localparam logic [7:0] OP_BEQ    = 8'h14;
  localparam logic [7:0] OP_BLE    = 8'h19;
  localparam logic [7:0] OP_BCI    = 8'h1a;
  localparam logic [7:0] OP_EXT1C  = 8'h1c;
  localparam logic [7:0] OP_EXT1D  = 8'h1d;
  localparam logic [7:0] OP_EXT1E  = 8'h1e;
  localparam logic [7:0] OP_KEYI   = 8'h1f;
  localparam logic [7:0] OP_EXT20  = 8'h20;
  localparam logic [7:0] OP_EXT21  = 8'h21;
  localparam logic [7:0] OP_EXT22  = 8'h22;
  localparam logic [7:0] OP_EXT23  = 8'h23;
  localparam logic [7:0] OP_EXT24  = 8'h24;
  localparam logic [7:0] OP_KEYR   = 8'h25;

  // alu operation codes
  typedef enum logic [3:0] {
    ALU_MOV = 4'd0, ALU_ADD = 4'd1, ALU_SUB = 4'd2, ALU_RSB = 4'd3,
    ALU_MUL = 4'd4, ALU_OR = 4'd5, ALU_AND = 4'd6, ALU_XOR = 4'd7,
    ALU_SHR = 4'd8, ALU_SHL = 4'd9, ALU_NONE = 4'd10
  } alu_op_t;

  localparam logic [3:0] FLAG_REG = 4'hf;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DISPATCH, ST_OPC, ST_B1, ST_B2, ST_B3, ST_B4, ST_B5,
    ST_WORD0, ST_WORD1, ST_POPWR0, ST_POPWR1, ST_MEMX, ST_EXEC, ST_DONE
  } state_t;

  // memory address source
  typedef enum logic [1:0] {
    MA_PC, MA_ADDR, MA_ADDR1, MA_IN
  } ma_sel_t;

  // controller to datapath
  typedef struct packed {
    logic    load_in;
    logic    key_wr;
    logic    mem_rd;
    logic    mem_wr;
    ma_sel_t ma_sel;
    logic    pc_inc;
    logic    wdata_in;     // write input data byte
    logic    wdata_reg;    // write register x
    logic    wdata_stk_hi;
    logic    wdata_stk_lo;
    logic    cap_op;
    logic    cap_b1;
    logic    cap_b2;
    logic    cap_b3;
    logic    cap_b4;
    logic    cap_w0;       // word read high byte
    logic    sp_pop;
    logic    exec;
    logic    clr_result;
    logic    out_load;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] op;
    logic [3:0] pair_lo;
  } sts_t;

  function automatic logic cond_eval(input logic [3:0] c, input logic [7:0] a,
                                     input logic [7:0] b);
    logic r;
    unique case (c)
      4'd0:    r = (a == b);
      4'd1:    r = (a != b);
      4'd2:    r = (a > b);
      4'd3:    r = (a < b);
      4'd4:    r = (a >= b);
      4'd5:    r = (a <= b);
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// File: hdl/bcc_if.sv
// bcc_if: valid/ready channel interfaces for input and result items
// no dependencies
interface bcc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] address;
  logic [7:0]  data;
  logic        key_down;
  modport source (output valid, cmd, address, data, key_down, input ready);
  modport sink (input valid, cmd, address, data, key_down, output ready);
endinterface

interface bcc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] prog_counter;
  logic [7:0]  flag_value;
  logic        external_op;
  logic [7:0]  opcode_seen;
  logic [7:0]  value_a;
  logic [7:0]  value_b;
  modport source (output valid, prog_counter, flag_value, external_op, opcode_seen,
                  value_a, value_b, input ready);
  modport sink (input valid, prog_counter, flag_value, external_op, opcode_seen,
                value_a, value_b, output ready);
endinterface

// File: hdl/byte_code_cpu_core.sv
// byte_code_cpu_core: top level joining controller, datapath and output register
// depends on bcc_pkg, bcc_if, bcc_ctrl, bcc_dp
//
// usage:
//   in channel: cmd selects memory byte write, key event, no operation or execute one
//   instruction fetched at pc. out channel: one item per input item with pc,
//   flag register, external marker, opcode and two register values.
// sequence: a memory write or key event passes DISPATCH and DONE before the
//   output register; an instruction passes DISPATCH, OPC, the operand states
//   from B1 on, up to two data-access states, EXEC and DONE; the single-port
//   byte memory, one access per cycle, sets this sequence.
// throughput: one item at a time; the next item can be accepted from the cycle
//   after the previous result is taken.
// reset: rst_n low clears registers, pc, stack pointer, key bitmap and the
//   output valid; memory and return stack hold no defined value until written.
// stall: a result waits in the output register while out.ready is low; no
//   new item is accepted until it is taken.
module byte_code_cpu_core (
  input logic clk,
  input logic rst_n,
  bcc_in_if.sink    in_ch,
  bcc_out_if.source out_ch
);
  import bcc_pkg::*;

  ctl_t ctl;
  sts_t sts;
  logic out_valid_r;
  logic [15:0] res_pc;
  logic [7:0]  res_flag, res_op, res_a, res_b;
  logic        res_ext;
  logic [15:0] pc_r;
  logic [7:0]  flag_r, op_r, a_r, b_r;
  logic        ext_r;

  bcc_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_busy (out_valid_r),
    .sts, .ctl
  );

  bcc_dp u_dp (
    .clk, .rst_n, .ctl, .sts,
    .in_cmd (in_ch.cmd), .in_address (in_ch.address),
    .in_data (in_ch.data), .in_key_down (in_ch.key_down),
    .res_pc, .res_flag, .res_ext, .res_op, .res_a, .res_b
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (ctl.out_load) out_valid_r <= 1'b1;
    else if (out_ch.ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      pc_r <= res_pc; flag_r <= res_flag; ext_r <= res_ext;
      op_r <= res_op; a_r <= res_a; b_r <= res_b;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.prog_counter = pc_r;
  assign out_ch.flag_value   = flag_r;
  assign out_ch.external_op  = ext_r;
  assign out_ch.opcode_seen  = op_r;
  assign out_ch.value_a      = a_r;
  assign out_ch.value_b      = b_r;

endmodule

// File: hdl/bcc_ctrl.sv
// bcc_ctrl: sequencing state machine, one memory access per cycle
// depends on bcc_pkg
module bcc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          out_busy,
  input  bcc_pkg::sts_t sts,
  output bcc_pkg::ctl_t ctl
);
  import bcc_pkg::*;

  state_t     state_r, state_nxt;
  logic [2:0] nb;     // operand bytes after the opcode
  logic       wd;     // needs word read at fetched address
  logic       popwr;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // operand byte count per opcode
  always_comb begin
    nb    = 3'd0;
    wd    = 1'b0;
    popwr = 1'b0;
    priority if (sts.op == OP_JMP || sts.op == OP_EXT05 || sts.op == OP_CALL)
      nb = 3'd2;
    else if (sts.op == OP_JMPI || sts.op == OP_PUSHM) begin
      nb = 3'd2; wd = 1'b1;
    end else if (sts.op == OP_POPM) begin
      nb = 3'd2; popwr = 1'b1;
    end else if (sts.op == OP_LDST)
      nb = 3'd3;
    else if (sts.op == OP_JMPR || sts.op == OP_MOV || sts.op == OP_EXT1C ||
             sts.op == OP_EXT1D || sts.op == OP_EXT20 || sts.op == OP_EXT22 ||
             sts.op == OP_EXT24 || (sts.op >= OP_ADD && sts.op <= OP_SHL))
      nb = 3'd1;
    else if (sts.op == OP_ALUI)
      nb = 3'd2;
    else if ((sts.op >= OP_BEQ && sts.op <= OP_BLE) || sts.op == OP_EXT1E ||
             sts.op == OP_KEYI || sts.op == OP_KEYR)
      nb = 3'd3;
    else if (sts.op == OP_BCI)
      nb = 3'd4;
    else if (sts.op == OP_EXT23)
      nb = 3'd5;
    else
      nb = 3'd0;
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    ctl.ma_sel = MA_PC;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = !out_busy;
        if (in_valid && !out_busy) begin
          ctl.load_in = 1'b1;
          state_nxt   = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        ctl.clr_result = 1'b1;
        priority case (sts.cmd)
          CMD_MEM_WR: begin
            ctl.mem_wr = 1'b1; ctl.ma_sel = MA_IN; ctl.wdata_in = 1'b1;
            state_nxt = ST_DONE;
          end
          CMD_KEY: begin
            ctl.key_wr = 1'b1; state_nxt = ST_DONE;
          end
          CMD_EXEC: begin
            ctl.mem_rd = 1'b1; ctl.pc_inc = 1'b1; state_nxt = ST_OPC;
          end
          default: state_nxt = ST_DONE;
        endcase
      end
      ST_OPC: begin
        ctl.cap_op = 1'b1;
        state_nxt  = ST_B1;
      end
      ST_B1, ST_B2, ST_B3, ST_B4, ST_B5: begin
        // capture the byte read last cycle, then read the next
        ctl.cap_b1 = (state_r == ST_B2);
        ctl.cap_b2 = (state_r == ST_B3);
        ctl.cap_b3 = (state_r == ST_B4);
        ctl.cap_b4 = (state_r == ST_B5);
        if ((state_r == ST_B1 && nb == 3'd0) || (state_r == ST_B2 && nb == 3'd1) ||
            (state_r == ST_B3 && nb == 3'd2) || (state_r == ST_B4 && nb == 3'd3) ||
            (state_r == ST_B5 && nb == 3'd4)) begin
          if (wd) begin
            state_nxt = ST_WORD0;
          end else if (popwr) begin
            ctl.sp_pop = 1'b1; state_nxt = ST_POPWR0;
          end else if (sts.op == OP_LDST) begin
            ctl.mem_rd = 1'b1; ctl.ma_sel = MA_ADDR; state_nxt = ST_MEMX;
          end else begin
            state_nxt = ST_EXEC;
          end
        end else begin
          ctl.mem_rd = 1'b1; ctl.pc_inc = 1'b1;
          unique case (state_r)
            ST_B1:   state_nxt = ST_B2;
            ST_B2:   state_nxt = ST_B3;
            ST_B3:   state_nxt = ST_B4;
            ST_B4:   state_nxt = ST_B5;
            default: state_nxt = ST_EXEC;  // fifth operand stays in the read register
          endcase
        end
      end
      ST_WORD0: begin
        ctl.mem_rd = 1'b1; ctl.ma_sel = MA_ADDR;
        state_nxt = ST_WORD1;
      end
      ST_WORD1: begin
        ctl.cap_w0 = 1'b1; ctl.mem_rd = 1'b1; ctl.ma_sel = MA_ADDR1;
        state_nxt = ST_EXEC;
      end
      ST_POPWR0: begin
        ctl.mem_wr = 1'b1; ctl.ma_sel = MA_ADDR; ctl.wdata_stk_hi = 1'b1;
        state_nxt = ST_POPWR1;
      end
      ST_POPWR1: begin
        ctl.mem_wr = 1'b1; ctl.ma_sel = MA_ADDR1; ctl.wdata_stk_lo = 1'b1;
        state_nxt = ST_EXEC;
      end
      ST_MEMX: begin
        // store happens here when selector is zero; load data is now valid
        ctl.cap_w0 = 1'b1;
        if (sts.pair_lo == 4'd0) begin
          ctl.mem_wr = 1'b1; ctl.ma_sel = MA_ADDR; ctl.wdata_reg = 1'b1;
        end
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        ctl.exec = 1'b1; state_nxt = ST_DONE;
      end
      ST_DONE: begin
        ctl.out_load = 1'b1; state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// File: hdl/bcc_dp.sv
// bcc_dp: register file, pc, return stack, key bitmap, byte memory and alu
// depends on bcc_pkg
module bcc_dp (
  input  logic          clk,
  input  logic          rst_n,
  input  bcc_pkg::ctl_t ctl,
  output bcc_pkg::sts_t sts,
  input  logic [1:0]    in_cmd,
  input  logic [15:0]   in_address,
  input  logic [7:0]    in_data,
  input  logic          in_key_down,
  output logic [15:0]   res_pc,
  output logic [7:0]    res_flag,
  output logic          res_ext,
  output logic [7:0]    res_op,
  output logic [7:0]    res_a,
  output logic [7:0]    res_b
);
  import bcc_pkg::*;

  logic [7:0]  mem [MEM_DEPTH];
  logic [15:0] rstk [STACK_DEPTH];

  logic [1:0]  cmd_r;
  logic [15:0] addr_in_r;
  logic [7:0]  data_in_r;
  logic        kd_r;
  logic [7:0]  regs_r [16];
  logic [15:0] pc_r;
  logic [SP_W-1:0] sp_r;
  logic [255:0] keys_r;
  logic [7:0]  op_r, b1_r, b2_r, b3_r, b4_r, w0_r;
  logic [7:0]  rdata_r;
  logic [15:0] stk_val_r;
  logic        ext_r, hp_r;
  logic [7:0]  pair_r;

  logic [15:0] ma, ea;
  logic [7:0]  wdata;
  logic [3:0]  rx, ry;
  logic [7:0]  vx, vy;

  assign rx = b1_r[7:4];
  assign ry = b1_r[3:0];
  assign vx = regs_r[rx];
  assign vy = regs_r[ry];

  // operand address: bytes at the position of the 16-bit operand
  always_comb begin
    priority if (op_r == OP_BCI)
      ea = {b3_r, b4_r};
    else if ((op_r >= OP_BEQ && op_r <= OP_BLE) || op_r == OP_KEYI || op_r == OP_KEYR)
      ea = {b2_r, b3_r};
    else
      ea = {b1_r, b2_r};
  end

  always_comb begin
    unique case (ctl.ma_sel)
      MA_PC:   ma = pc_r;
      MA_ADDR: ma = ea;
      MA_ADDR1: ma = ea + 16'd1;
      MA_IN:   ma = addr_in_r;
    endcase
    priority if (ctl.wdata_in)     wdata = data_in_r;
    else if (ctl.wdata_stk_hi)     wdata = stk_val_r[15:8];
    else if (ctl.wdata_stk_lo)     wdata = stk_val_r[7:0];
    else if (ctl.wdata_reg)        wdata = regs_r[b3_r[7:4]];
    else                           wdata = 8'd0;
  end

  always_ff @(posedge clk) begin
    if (ctl.mem_wr) mem[ma[MEM_AW-1:0]] <= wdata;
    if (ctl.mem_rd) rdata_r <= mem[ma[MEM_AW-1:0]];
  end

  assign sts.cmd     = cmd_r;
  assign sts.op      = op_r;
  assign sts.pair_lo = b3_r[3:0];

  // alu
  logic [3:0]  dst, aop;
  logic [7:0]  aa, ab, ares;
  logic        aflag, fl_wr, d_wr;
  logic [15:0] prod;
  logic [8:0]  sum;
  logic        br;

  always_comb begin
    dst = rx; aa = vx; ab = vy; aop = ALU_NONE;
    if (op_r == OP_ALUI) begin
      dst = ry; aa = vy; ab = b2_r;
      aop = (rx <= 4'd9) ? rx : ALU_NONE;
      if (rx == ALU_RSB) begin aa = b2_r; ab = vy; end
    end else if (op_r == OP_MOV) begin
      dst = ry; aa = vx; ab = vx; aop = ALU_MOV;
      ab = vx;
    end else if (op_r >= OP_ADD && op_r <= OP_SHL) begin
      unique case (op_r)
        OP_ADD: aop = ALU_ADD;
        OP_SUB: aop = ALU_SUB;
        OP_RSB: begin aop = ALU_SUB; aa = vy; ab = vx; end
        OP_MUL: aop = ALU_MUL;
        OP_OR:  aop = ALU_OR;
        OP_AND: aop = ALU_AND;
        OP_XOR: aop = ALU_XOR;
        OP_SHR: aop = ALU_SHR;
        default: aop = ALU_SHL;
      endcase
    end
    if (aop == ALU_RSB) aop = ALU_SUB;
    sum   = {1'b0, aa} + {1'b0, ab};
    prod  = aa * ab;
    ares  = 8'd0; aflag = 1'b0; fl_wr = 1'b0; d_wr = 1'b1;
    unique case (aop)
      ALU_MOV: ares = (op_r == OP_MOV) ? vx : ab;
      ALU_ADD: begin ares = sum[7:0]; aflag = sum[8]; fl_wr = 1'b1; end
      ALU_SUB: begin ares = aa - ab; aflag = (aa < ab); fl_wr = 1'b1; end
      ALU_MUL: begin ares = prod[7:0]; aflag = (prod[15:8] != 8'd0); fl_wr = 1'b1; end
      ALU_OR:  ares = aa | ab;
      ALU_AND: ares = aa & ab;
      ALU_XOR: ares = aa ^ ab;
      ALU_SHR: ares = (ab >= 8'd8) ? 8'd0 : (aa >> ab[2:0]);
      ALU_SHL: ares = (ab >= 8'd8) ? 8'd0 : (aa << ab[2:0]);
      default: d_wr = 1'b0;
    endcase
    if (op_r == OP_BCI) br = cond_eval(ry, vx, b2_r);
    else br = cond_eval(op_r[3:0] - 4'd4, vx, vy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) regs_r[i] <= 8'd0;
      pc_r   <= 16'd0;
      sp_r   <= '0;
      keys_r <= '0;
    end else begin
      if (ctl.key_wr) keys_r[data_in_r] <= kd_r;
      if (ctl.pc_inc) pc_r <= pc_r + 16'd1;
      if (ctl.sp_pop) begin
        stk_val_r <= rstk[sp_r - 1'b1];
        sp_r      <= sp_r - 1'b1;
      end
      if (ctl.exec) begin
        if (fl_wr) regs_r[FLAG_REG] <= {7'd0, aflag};
        if (d_wr && (op_r == OP_MOV || op_r == OP_ALUI ||
                     (op_r >= OP_ADD && op_r <= OP_SHL)))
          regs_r[dst] <= ares;
        unique case (op_r)
          OP_JMP:  pc_r <= {b1_r, b2_r};
          OP_JMPI: pc_r <= {w0_r, rdata_r};
          OP_JMPR: pc_r <= {vx, vy};
          OP_LDST: if (b3_r[3:0] == 4'd1) regs_r[b3_r[7:4]] <= w0_r;
          OP_RET: begin
            pc_r <= rstk[sp_r - 1'b1];
            sp_r <= sp_r - 1'b1;
          end
          OP_CALL: begin
            rstk[sp_r] <= pc_r - 16'd2;
            sp_r <= sp_r + 1'b1;
            pc_r <= {b1_r, b2_r};
          end
          OP_PUSHM: begin
            rstk[sp_r] <= {w0_r, rdata_r};
            sp_r <= sp_r + 1'b1;
          end
          OP_BCI:  if (br) pc_r <= ea;
          OP_KEYI: if (keys_r[b1_r]) pc_r <= ea;
          OP_KEYR: if (keys_r[vy]) pc_r <= ea;
          default: if (op_r >= OP_BEQ && op_r <= OP_BLE && br) pc_r <= ea;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      cmd_r <= in_cmd; addr_in_r <= in_address; data_in_r <= in_data; kd_r <= in_key_down;
    end
    if (ctl.clr_result) op_r <= 8'd0;
    if (ctl.cap_op) op_r <= rdata_r;
    if (ctl.cap_b1) b1_r <= rdata_r;
    if (ctl.cap_b2) b2_r <= rdata_r;
    if (ctl.cap_b3) b3_r <= rdata_r;
    if (ctl.cap_b4) b4_r <= rdata_r;
    if (ctl.cap_w0) w0_r <= rdata_r;
  end

  // external op report
  always_comb begin
    ext_r = 1'b0; hp_r = 1'b0; pair_r = b1_r;
    if (cmd_r == CMD_EXEC) begin
      if (op_r == OP_LDST && (b3_r[3:0] == 4'd2 || b3_r[3:0] == 4'd3)) begin
        ext_r = 1'b1; hp_r = 1'b1; pair_r = b3_r;
      end else if (op_r == OP_EXT20 || op_r == OP_EXT22 || op_r == OP_EXT24) begin
        ext_r = 1'b1; hp_r = 1'b1;
      end else if (op_r == OP_EXT23) begin
        ext_r = 1'b1; hp_r = 1'b1; pair_r = rdata_r;
      end else if (op_r == OP_EXT05 || op_r == OP_EXT1C || op_r == OP_EXT1D ||
                   op_r == OP_EXT1E || op_r == OP_EXT21)
        ext_r = 1'b1;
    end
  end

  assign res_pc   = pc_r;
  assign res_flag = regs_r[FLAG_REG];
  assign res_ext  = ext_r;
  assign res_op   = (cmd_r == CMD_EXEC) ? op_r : 8'd0;
  assign res_a    = hp_r ? regs_r[pair_r[7:4]] : 8'd0;
  assign res_b    = hp_r ? regs_r[pair_r[3:0]] : 8'd0;

endmodule

// File: hdl/bcc_checker.sv
// bcc_checker: port-level assertions for byte_code_cpu_core
// depends on bcc_if and byte_code_cpu_core, attached by bind
module bcc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [7:0] out_opcode_seen,
  input logic out_external_op
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_opcode_seen))
    else $error("result dropped under stall");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("item accepted while result pending");
  a_accept_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !out_valid)
    else $error("result too early");
  a_ext_op: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_external_op |-> out_opcode_seen != 8'd0)
    else $error("external without opcode");
endmodule

bind byte_code_cpu_core bcc_checker u_bcc_checker (
  .clk (clk), .rst_n (rst_n),
  .in_valid (in_ch.valid), .in_ready (in_ch.ready),
  .out_valid (out_ch.valid), .out_ready (out_ch.ready),
  .out_opcode_seen (out_ch.opcode_seen), .out_external_op (out_ch.external_op)
);

// File: tb/byte_code_cpu_core_tb.sv
// byte_code_cpu_core_tb: self-checking bench for the byte-code cpu core
// builds programs in memory, executes them and checks every result item
// depends on bcc_pkg, bcc_if and the byte_code_cpu_core rtl
`timescale 1ns / 100ps

module byte_code_cpu_core_tb;
  import bcc_pkg::*;

  typedef logic [7:0] u8;

  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] addr;
    u8           data;
    logic        key_down;
  } req_t;

  typedef struct packed {
    logic [15:0] pc;
    u8           flag;
    logic        ext;
    u8           op;
    u8           va;
    u8           vb;
  } res_t;

  logic clk;
  logic rst_n;

  bcc_in_if  in_ch ();
  bcc_out_if out_ch ();

  byte_code_cpu_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // shadow machine state
  u8           mem_img [0:65535];
  bit          mem_set [0:65535];
  u8           regs [16];
  logic [15:0] shadow_pc;
  logic [15:0] ret_stk [16];
  bit          ret_set [16];
  logic [3:0]  ret_sp;
  bit          keys [256];

  req_t pending_q[$];
  res_t result_q[$];

  int n_items, n_exec, n_ext, n_keys, n_errors, n_checked;
  bit calm_in, calm_out;
  int gap_in, stall_out, idle_cycles;

  function automatic void mem_put(logic [15:0] a, u8 v);
    mem_img[a] = v;
    mem_set[a] = 1'b1;
  endfunction

  function automatic u8 fetch_byte();
    u8 b;
    b = mem_img[shadow_pc];
    shadow_pc = shadow_pc + 16'd1;
    return b;
  endfunction

  function automatic logic [15:0] fetch_word();
    u8 hi, lo;
    hi = fetch_byte();
    lo = fetch_byte();
    return {hi, lo};
  endfunction

  function automatic logic [15:0] word_at(logic [15:0] a);
    logic [15:0] a1;
    a1 = a + 16'd1;
    return {mem_img[a], mem_img[a1]};
  endfunction

  function automatic void push_ret(logic [15:0] v);
    ret_stk[ret_sp] = v;
    ret_set[ret_sp] = 1'b1;
    ret_sp = ret_sp + 4'd1;
  endfunction

  function automatic logic [15:0] pop_ret();
    ret_sp = ret_sp - 4'd1;
    return ret_stk[ret_sp];
  endfunction

  function automatic bit compare(logic [3:0] c, u8 a, u8 b);
    case (c)
      4'd0: return a == b;
      4'd1: return a != b;
      4'd2: return a > b;
      4'd3: return a < b;
      4'd4: return a >= b;
      4'd5: return a <= b;
      default: return 1'b0;
    endcase
  endfunction

  // flag is written first so a flag destination overwrites it
  function automatic void do_add(logic [3:0] d, u8 a, u8 b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    regs[FLAG_REG] = {7'd0, s[8]};
    regs[d] = s[7:0];
  endfunction

  function automatic void do_sub(logic [3:0] d, u8 a, u8 b);
    regs[FLAG_REG] = {7'd0, a < b};
    regs[d] = a - b;
  endfunction

  function automatic void do_mul(logic [3:0] d, u8 a, u8 b);
    logic [15:0] p;
    p = a * b;
    regs[FLAG_REG] = {7'd0, p > 16'd255};
    regs[d] = p[7:0];
  endfunction

  function automatic u8 shift_r(u8 v, u8 n);
    return n >= 8 ? 8'd0 : v >> n;
  endfunction

  function automatic u8 shift_l(u8 v, u8 n);
    return n >= 8 ? 8'd0 : v << n;
  endfunction

  function automatic res_t cpu_step(req_t r);
    res_t o;
    u8 op, pr, v;
    logic [3:0] x, y;
    logic [15:0] a, w;
    bit ext, has_pair;
    op = 8'd0; pr = 8'd0; ext = 0; has_pair = 0;
    if (r.cmd == CMD_MEM_WR) begin
      mem_put(r.addr, r.data);
    end else if (r.cmd == CMD_KEY) begin
      keys[r.data] = r.key_down;
    end else if (r.cmd == CMD_EXEC) begin
      op = fetch_byte();
      case (op)
        OP_JMP: shadow_pc = fetch_word();
        OP_JMPI: begin
          a = fetch_word();
          shadow_pc = word_at(a);
        end
        OP_JMPR: begin
          pr = fetch_byte();
          shadow_pc = {regs[pr[7:4]], regs[pr[3:0]]};
        end
        OP_MOV: begin
          pr = fetch_byte();
          regs[pr[3:0]] = regs[pr[7:4]];
        end
        OP_LDST: begin
          a = fetch_word();
          pr = fetch_byte();
          x = pr[7:4]; y = pr[3:0];
          if (y == 4'd0) mem_put(a, regs[x]);
          else if (y == 4'd1) regs[x] = mem_img[a];
          else if (y == 4'd2 || y == 4'd3) begin
            ext = 1; has_pair = 1;
          end
        end
        OP_EXT05: begin
          a = fetch_word();
          ext = 1;
        end
        OP_ALUI: begin
          pr = fetch_byte();
          v = fetch_byte();
          x = pr[7:4]; y = pr[3:0];
          case (alu_op_t'(x))
            ALU_MOV: regs[y] = v;
            ALU_ADD: do_add(y, regs[y], v);
            ALU_SUB: do_sub(y, regs[y], v);
            ALU_RSB: do_sub(y, v, regs[y]);
            ALU_MUL: do_mul(y, regs[y], v);
            ALU_OR:  regs[y] = regs[y] | v;
            ALU_AND: regs[y] = regs[y] & v;
            ALU_XOR: regs[y] = regs[y] ^ v;
            ALU_SHR: regs[y] = shift_r(regs[y], v);
            ALU_SHL: regs[y] = shift_l(regs[y], v);
            default: ;
          endcase
        end
        OP_ADD, OP_SUB, OP_RSB, OP_MUL, OP_OR, OP_AND, OP_XOR, OP_SHR, OP_SHL: begin
          pr = fetch_byte();
          x = pr[7:4]; y = pr[3:0];
          case (op)
            OP_ADD: do_add(x, regs[x], regs[y]);
            OP_SUB: do_sub(x, regs[x], regs[y]);
            OP_RSB: do_sub(x, regs[y], regs[x]);
            OP_MUL: do_mul(x, regs[x], regs[y]);
            OP_OR:  regs[x] = regs[x] | regs[y];
            OP_AND: regs[x] = regs[x] & regs[y];
            OP_XOR: regs[x] = regs[x] ^ regs[y];
            OP_SHR: regs[x] = shift_r(regs[x], regs[y]);
            default: regs[x] = shift_l(regs[x], regs[y]);
          endcase
        end
        OP_RET: shadow_pc = pop_ret();
        OP_CALL: begin
          push_ret(shadow_pc);
          shadow_pc = fetch_word();
        end
        OP_POPM: begin
          w = pop_ret();
          a = fetch_word();
          mem_put(a, w[15:8]);
          mem_put(a + 16'd1, w[7:0]);
        end
        OP_PUSHM: begin
          a = fetch_word();
          push_ret(word_at(a));
        end
        OP_BCI: begin
          pr = fetch_byte();
          v = fetch_byte();
          a = fetch_word();
          if (compare(pr[3:0], regs[pr[7:4]], v)) shadow_pc = a;
        end
        OP_EXT1C, OP_EXT1D: begin
          v = fetch_byte();
          ext = 1;
        end
        OP_EXT1E: begin
          v = fetch_byte();
          a = fetch_word();
          ext = 1;
        end
        OP_KEYI: begin
          v = fetch_byte();
          a = fetch_word();
          if (keys[v]) shadow_pc = a;
        end
        OP_EXT20, OP_EXT22, OP_EXT24: begin
          pr = fetch_byte();
          ext = 1; has_pair = 1;
        end
        OP_EXT21: ext = 1;
        OP_EXT23: begin
          a = fetch_word();
          a = fetch_word();
          pr = fetch_byte();
          ext = 1; has_pair = 1;
        end
        OP_KEYR: begin
          pr = fetch_byte();
          a = fetch_word();
          if (keys[regs[pr[3:0]]]) shadow_pc = a;
        end
        default: begin
          if (op >= OP_BEQ && op <= OP_BLE) begin
            pr = fetch_byte();
            a = fetch_word();
            if (compare(4'(op - OP_BEQ), regs[pr[7:4]], regs[pr[3:0]])) shadow_pc = a;
          end
        end
      endcase
    end
    o.pc = shadow_pc;
    o.flag = regs[FLAG_REG];
    o.ext = ext;
    o.op = op;
    o.va = has_pair ? regs[pr[7:4]] : 8'd0;
    o.vb = has_pair ? regs[pr[3:0]] : 8'd0;
    return o;
  endfunction

  function automatic int instr_len(u8 op);
    case (op)
      OP_JMP, OP_JMPI, OP_EXT05, OP_ALUI, OP_CALL, OP_POPM, OP_PUSHM: return 3;
      OP_JMPR, OP_MOV, OP_EXT1C, OP_EXT1D, OP_EXT20, OP_EXT22, OP_EXT24: return 2;
      OP_LDST, OP_EXT1E, OP_KEYI, OP_KEYR: return 4;
      OP_BCI: return 5;
      OP_EXT23: return 6;
      default: begin
        if (op >= OP_ADD && op <= OP_SHL) return 2;
        if (op >= OP_BEQ && op <= OP_BLE) return 4;
        return 1;
      end
    endcase
  endfunction

  task automatic send(cmd_t c, logic [15:0] a, u8 d, logic k);
    req_t r;
    r.cmd = c; r.addr = a; r.data = d; r.key_down = k;
    pending_q.push_back(r);
    result_q.push_back(cpu_step(r));
    n_items++;
    if (c == CMD_EXEC) n_exec++;
    if (c == CMD_KEY) n_keys++;
  endtask

  task automatic fill_if_unset(logic [15:0] a);
    if (!mem_set[a]) send(CMD_MEM_WR, a, u8'($urandom_range(0, 255)), 1'b0);
  endtask

  // place the instruction bytes at pc and run it
  task automatic run_instr(u8 b[6]);
    int n;
    logic [15:0] base;
    n = instr_len(b[0]);
    base = shadow_pc;
    for (int i = 0; i < n; i++) send(CMD_MEM_WR, base + 16'(i), b[i], 1'b0);
    send(CMD_EXEC, 16'($urandom_range(0, 65535)), u8'($urandom_range(0, 255)),
         1'($urandom_range(0, 1)));
  endtask

  task automatic random_instr();
    u8 b[6];
    u8 op;
    logic [15:0] a;
    if ($urandom_range(0, 99) < 6) begin
      if ($urandom_range(0, 3) == 0) op = OP_BCI + 8'd1;
      else op = OP_KEYR + 8'd1 + u8'($urandom_range(0, 255 - OP_KEYR - 1));
    end else begin
      op = u8'($urandom_range(0, OP_KEYR));
      if (op == OP_BCI + 8'd1) op = OP_BCI;
    end
    if ((op == OP_RET || op == OP_POPM) && !ret_set[ret_sp - 4'd1]) op = OP_CALL;
    b[0] = op;
    for (int i = 1; i < 6; i++) b[i] = u8'($urandom_range(0, 255));
    if (op == OP_LDST && $urandom_range(0, 9) < 7) b[3][3:0] = 4'($urandom_range(0, 3));
    if (op == OP_ALUI && $urandom_range(0, 9) < 8) b[1][7:4] = 4'($urandom_range(0, 9));
    if (op == OP_BCI && $urandom_range(0, 9) < 8) b[1][3:0] = 4'($urandom_range(0, 5));
    if ((op == OP_ALUI || op == OP_SHR || op == OP_SHL) && $urandom_range(0, 1))
      b[2] = u8'($urandom_range(0, 10));
    a = {b[1], b[2]};
    if (op == OP_JMPI || op == OP_PUSHM) begin
      fill_if_unset(a);
      fill_if_unset(a + 16'd1);
    end
    if (op == OP_LDST && b[3][3:0] == 4'd1) fill_if_unset(a);
    run_instr(b);
  endtask

  task automatic report(string field, int got, int want);
    $display("mismatch on item %0d: %s got %0h expected %0h", n_checked, field, got, want);
    n_errors++;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      gap_in <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (gap_in > 0) begin
        gap_in <= gap_in - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        req_t r;
        r = pending_q.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.cmd <= r.cmd;
        in_ch.address <= r.addr;
        in_ch.data <= r.data;
        in_ch.key_down <= r.key_down;
        if ($urandom_range(0, 40) == 0) calm_in = !calm_in;
        gap_in <= calm_in ? 0 : $urandom_range(0, 15);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_out <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        res_t e;
        n_checked++;
        if (out_ch.external_op) n_ext++;
        if (result_q.size() == 0) begin
          $display("unexpected result item %0d", n_checked);
          n_errors++;
        end else begin
          e = result_q.pop_front();
          if (out_ch.prog_counter !== e.pc) report("prog_counter", out_ch.prog_counter, e.pc);
          if (out_ch.flag_value !== e.flag) report("flag_value", out_ch.flag_value, e.flag);
          if (out_ch.external_op !== e.ext) report("external_op", out_ch.external_op, e.ext);
          if (out_ch.opcode_seen !== e.op) report("opcode_seen", out_ch.opcode_seen, e.op);
          if (out_ch.value_a !== e.va) report("value_a", out_ch.value_a, e.va);
          if (out_ch.value_b !== e.vb) report("value_b", out_ch.value_b, e.vb);
        end
        if ($urandom_range(0, 40) == 0) calm_out = !calm_out;
        if (calm_out) begin
          stall_out <= 0;
          out_ch.ready <= 1'b1;
        end else begin
          stall_out <= $urandom_range(0, 15);
          out_ch.ready <= 1'b0;
        end
      end else if (stall_out > 0) begin
        stall_out <= stall_out - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= 3000) begin
        $display("timeout with %0d results outstanding", result_q.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    u8 b[6];
    int r;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_NOP;
    in_ch.address = 16'd0;
    in_ch.data = 8'd0;
    in_ch.key_down = 1'b0;
    out_ch.ready = 1'b0;
    idle_cycles = 0;
    calm_in = 0;
    calm_out = 0;
    foreach (regs[i]) regs[i] = 8'd0;
    foreach (ret_set[i]) ret_set[i] = 1'b0;
    foreach (keys[i]) keys[i] = 1'b0;
    shadow_pc = 16'd0;
    ret_sp = 4'd0;

    // directed: keys, unused command, top address, alu corners, pc wrap
    send(CMD_KEY, 16'hffff, 8'hff, 1'b1);
    send(CMD_KEY, 16'h0000, 8'h00, 1'b1);
    send(CMD_KEY, 16'h0000, 8'h00, 1'b0);
    send(CMD_NOP, 16'hffff, 8'hff, 1'b1);
    send(CMD_MEM_WR, 16'hffff, 8'hff, 1'b1);
    b = '{OP_ALUI, {ALU_MOV, 4'd1}, 8'hff, 0, 0, 0};
    run_instr(b);
    b = '{OP_ALUI, {ALU_MUL, 4'd1}, 8'hff, 0, 0, 0};
    run_instr(b);
    b = '{OP_ALUI, {ALU_SHR, 4'd1}, 8'd8, 0, 0, 0};
    run_instr(b);
    b = '{OP_ALUI, {ALU_MOV, FLAG_REG}, 8'hff, 0, 0, 0};
    run_instr(b);
    b = '{OP_ALUI, {ALU_ADD, FLAG_REG}, 8'h01, 0, 0, 0};
    run_instr(b);
    b = '{OP_JMP, 8'hff, 8'hff, 0, 0, 0};
    run_instr(b);
    b = '{OP_ALUI, {ALU_SUB, 4'd2}, 8'h01, 0, 0, 0};
    run_instr(b);

    while (n_items < 1050) begin
      r = $urandom_range(0, 99);
      if (r < 72) random_instr();
      else if (r < 82)
        send(CMD_KEY, 16'($urandom_range(0, 65535)), u8'($urandom_range(0, 255)),
             1'($urandom_range(0, 1)));
      else if (r < 87)
        send(CMD_NOP, 16'($urandom_range(0, 65535)), u8'($urandom_range(0, 255)),
             1'($urandom_range(0, 1)));
      else
        send(CMD_MEM_WR, 16'($urandom_range(0, 65535)), u8'($urandom_range(0, 255)),
             1'($urandom_range(0, 1)));
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_q.size() == 0 && result_q.size() == 0);
    repeat (30) @(posedge clk);
    $display("ran %0d items: %0d instructions, %0d key events, %0d external ops reported",
             n_items, n_exec, n_keys, n_ext);
    if (n_errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
